// File: hw/rtl/tilt_range_gesture_detector_macros.svh
// Assertion macros for the tilt range gesture detector.
// Included by modules that carry concurrent checks; no other dependencies.
`ifndef TILT_RANGE_GESTURE_DETECTOR_MACROS_SVH
`define TILT_RANGE_GESTURE_DETECTOR_MACROS_SVH
// implication checked on every clock edge outside reset
`define TRGD_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// check that also holds during reset
`define TRGD_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`endif

// File: hw/rtl/trgd_pkg.sv
// Package for the tilt range gesture detector: sizes, CORDIC angle table,
// state encodings and configuration register indexes. No dependencies.
package trgd_pkg;
    localparam int WindowDepth = 16;
    localparam int SlotW       = $clog2(WindowDepth);
    localparam int CordicSteps = 20;
    localparam int StepW       = 5;
    localparam int SqrtSteps   = 24;
    localparam int SqrtW       = 5;
    localparam int PitchLimit  = 23040;
    localparam int CxW         = 36;
    localparam int AngW        = 24;

    localparam logic [1:0] CfgEnable    = 2'd0;
    localparam logic [1:0] CfgThreshold = 2'd1;
    localparam logic [1:0] CfgInterval  = 2'd2;
    localparam logic [1:0] CfgDebounce  = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE, ST_SQRT, ST_CORDIC, ST_ROUND, ST_SCAN, ST_DONE, ST_OUT
    } t_state;

    function automatic logic [AngW-1:0] atan_q16(input logic [StepW-1:0] i);
        logic [AngW-1:0] v;
        case (i)
            5'd0: v = 24'd2949120;  5'd1: v = 24'd1740967;
            5'd2: v = 24'd919879;   5'd3: v = 24'd466945;
            5'd4: v = 24'd234379;   5'd5: v = 24'd117305;
            5'd6: v = 24'd58666;    5'd7: v = 24'd29335;
            5'd8: v = 24'd14668;    5'd9: v = 24'd7334;
            5'd10: v = 24'd3667;    5'd11: v = 24'd1833;
            5'd12: v = 24'd917;     5'd13: v = 24'd458;
            5'd14: v = 24'd229;     5'd15: v = 24'd115;
            5'd16: v = 24'd57;      5'd17: v = 24'd29;
            5'd18: v = 24'd14;      5'd19: v = 24'd7;
            default: v = '0;
        endcase
        return v;
    endfunction
endpackage

// File: hw/rtl/tilt_range_gesture_detector.sv
// Tilt range gesture detector: one transaction in, one result out.
// A taken sample passes through square root (24 steps), CORDIC (20 steps), round,
// window scan and compare; CORDIC iterations are skipped when the pitch is zero or
// vertical, and a dropped sample goes straight to the output. One item at a time:
// a new sample is accepted only after the last result is taken by the output.
// Reset (synchronous, active low) clears control state and the window valid bits,
// so window entries never written read as zero pitch.
`include "tilt_range_gesture_detector_macros.svh"
module tilt_range_gesture_detector (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [15:0] accel_x, [31:16] accel_y, [47:32] accel_z, [79:48] now_ms
    input  logic [79:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [0] gesture_detected, [1] sample_taken, [17:2] pitch_angle, [23:18] zero
    output logic [23:0] m_axis_tdata,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);
    localparam int D = trgd_pkg::WindowDepth;
    localparam int SW = trgd_pkg::SlotW;
    localparam int CW = trgd_pkg::CxW;
    localparam int AW = trgd_pkg::AngW;
    localparam int PitchQ16 = trgd_pkg::PitchLimit * 256;

    trgd_pkg::t_state r_state, n_state;

    logic        r_enable;
    logic [15:0] r_threshold, r_interval;
    logic [5:0]  r_deb_ticks, r_deb_left;
    logic [31:0] r_last_ms;
    logic [SW-1:0] r_slot;
    logic [D-1:0]  r_valid;

    logic signed [15:0] r_ax;
    logic [33:0] r_rem;       // sqrt remainder over 48-bit radicand
    logic [47:0] r_rad;
    logic [23:0] r_root;
    logic [4:0]  r_cnt;
    logic signed [CW-1:0] r_cx, r_cy;
    logic signed [AW+1:0] r_ang;
    logic signed [15:0] r_pitch, r_mn, r_mx;
    logic [SW:0] r_scan;
    logic        r_hit, r_taken;

    logic signed [15:0] mem [D];
    logic signed [15:0] r_rd;

    logic in_acc, out_acc;
    assign in_acc  = s_axis_tvalid && s_axis_tready;
    assign out_acc = m_axis_tvalid && m_axis_tready;
    assign s_axis_tready = (r_state == trgd_pkg::ST_IDLE);

    // y^2 + z^2 of the incoming sample
    logic signed [31:0] in_ay, in_az;
    logic [31:0] in_sq;
    assign in_ay = {{16{s_axis_tdata[31]}}, s_axis_tdata[31:16]};
    assign in_az = {{16{s_axis_tdata[47]}}, s_axis_tdata[47:32]};
    assign in_sq = in_ay * in_ay + in_az * in_az;

    // window scan: the entry read last cycle, the new pitch forwarded for its slot
    logic [SW-1:0] sc_idx;
    logic signed [15:0] sc_val;
    logic [16:0] range_w;
    assign sc_idx = r_scan[SW-1:0] - SW'(1);
    assign sc_val = (sc_idx == r_slot) ? r_pitch : (r_valid[sc_idx] ? r_rd : 16'sd0);
    assign range_w = {r_mx[15], r_mx} - {r_mn[15], r_mn};

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            trgd_pkg::ST_IDLE: if (in_acc) begin
                if (!r_enable || (s_axis_tdata[79:48] - r_last_ms) < {16'd0, r_interval})
                    n_state = trgd_pkg::ST_OUT;
                else
                    n_state = trgd_pkg::ST_SQRT;
            end
            trgd_pkg::ST_SQRT:   if (r_cnt == 5'(trgd_pkg::SqrtSteps - 1))
                n_state = trgd_pkg::ST_CORDIC;
            trgd_pkg::ST_CORDIC: if ((r_cnt == '0 && (r_cy == '0 || r_cx == '0)) ||
                                     r_cnt == 5'(trgd_pkg::CordicSteps - 1))
                n_state = trgd_pkg::ST_ROUND;
            trgd_pkg::ST_ROUND:  n_state = trgd_pkg::ST_SCAN;
            trgd_pkg::ST_SCAN:   if (r_scan == (SW+1)'(D)) n_state = trgd_pkg::ST_DONE;
            trgd_pkg::ST_DONE:   n_state = trgd_pkg::ST_OUT;
            trgd_pkg::ST_OUT:    if (out_acc) n_state = trgd_pkg::ST_IDLE;
            default:             n_state = trgd_pkg::ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        m_axis_tvalid = (r_state == trgd_pkg::ST_OUT);
        m_axis_tdata  = {6'd0, r_pitch, r_taken, r_hit};
    end

    // sqrt step
    logic [33:0] sq_trial, sq_rem;
    always_comb begin
        sq_rem   = {r_rem[31:0], r_rad[47:46]};
        sq_trial = sq_rem - {8'd0, r_root, 2'b01};
    end

    // CORDIC step
    logic signed [CW-1:0] dx, dy;
    always_comb begin
        dx = r_cy >>> r_cnt;
        dy = r_cx >>> r_cnt;
    end

    logic signed [AW+1:0] rnd;
    logic signed [AW-7:0] q;
    assign rnd = r_ang + (AW+2)'(128);
    assign q   = rnd[AW+1:8];

    always_ff @(posedge i_clk) begin
        if (r_state == trgd_pkg::ST_DONE) mem[r_slot] <= r_pitch;
        r_rd <= mem[r_scan[SW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= trgd_pkg::ST_IDLE;
            r_enable <= 1'b1; r_threshold <= 16'd5120;
            r_interval <= 16'd20; r_deb_ticks <= 6'd40;
            r_deb_left <= '0; r_last_ms <= '0; r_slot <= '0; r_valid <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    trgd_pkg::CfgEnable:    r_enable    <= i_cfg_data[0];
                    trgd_pkg::CfgThreshold: r_threshold <= i_cfg_data;
                    trgd_pkg::CfgInterval:  r_interval  <= i_cfg_data;
                    trgd_pkg::CfgDebounce:  r_deb_ticks <= i_cfg_data[5:0];
                    default: ;
                endcase
            end
            if (r_state == trgd_pkg::ST_IDLE && n_state == trgd_pkg::ST_SQRT)
                r_last_ms <= s_axis_tdata[79:48];
            if (r_state == trgd_pkg::ST_DONE) begin
                r_valid[r_slot] <= 1'b1;
                r_slot <= (r_slot == SW'(D - 1)) ? '0 : r_slot + 1'b1;
                if (r_deb_left == '0 && range_w > {1'b0, r_threshold})
                    r_deb_left <= r_deb_ticks;
                else if (r_deb_left != '0)
                    r_deb_left <= r_deb_left - 1'b1;
            end
        end
    end

    // datapath, no reset
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            trgd_pkg::ST_IDLE: begin
                r_ax <= s_axis_tdata[15:0];
                r_rad <= {in_sq, 16'd0};
                r_rem <= '0; r_root <= '0; r_cnt <= '0;
                r_hit <= 1'b0;
                r_taken <= (n_state == trgd_pkg::ST_SQRT);
                r_pitch <= '0;
            end
            trgd_pkg::ST_SQRT: begin
                r_rad <= {r_rad[45:0], 2'b00};
                if (!sq_trial[33]) begin
                    r_rem <= sq_trial; r_root <= {r_root[22:0], 1'b1};
                end else begin
                    r_rem <= sq_rem;   r_root <= {r_root[22:0], 1'b0};
                end
                if (r_cnt == 5'(trgd_pkg::SqrtSteps - 1)) begin
                    r_cnt <= '0;
                    r_cx  <= CW'({!sq_trial[33] ? {r_root[22:0], 1'b1} : {r_root[22:0], 1'b0}});
                    r_cy  <= -(CW'(r_ax) <<< 8);
                    r_ang <= '0;
                end else r_cnt <= r_cnt + 1'b1;
            end
            trgd_pkg::ST_CORDIC: begin
                if (r_cnt == '0 && r_cy == '0) begin
                    r_ang <= '0; r_cnt <= '0;
                end else if (r_cnt == '0 && r_cx == '0) begin
                    r_ang <= r_cy > 0 ? (AW+2)'(PitchQ16) : -(AW+2)'(PitchQ16);
                end else begin
                    if (r_cy > 0) begin
                        r_cx <= r_cx + dx; r_cy <= r_cy - dy;
                        r_ang <= r_ang + (AW+2)'(trgd_pkg::atan_q16(r_cnt));
                    end else begin
                        r_cx <= r_cx - dx; r_cy <= r_cy + dy;
                        r_ang <= r_ang - (AW+2)'(trgd_pkg::atan_q16(r_cnt));
                    end
                    r_cnt <= r_cnt + 1'b1;
                end
            end
            trgd_pkg::ST_ROUND: begin
                r_scan <= '0;
                if (q > (AW-6)'(trgd_pkg::PitchLimit))
                    r_pitch <= 16'(trgd_pkg::PitchLimit);
                else if (q < -(AW-6)'(trgd_pkg::PitchLimit))
                    r_pitch <= -16'(trgd_pkg::PitchLimit);
                else
                    r_pitch <= q[15:0];
            end
            trgd_pkg::ST_SCAN: begin
                r_scan <= r_scan + 1'b1;
                if (r_scan == (SW+1)'(1)) begin
                    r_mn <= sc_val; r_mx <= sc_val;
                end else if (r_scan != '0) begin
                    if (sc_val < r_mn) r_mn <= sc_val;
                    if (sc_val > r_mx) r_mx <= sc_val;
                end
            end
            trgd_pkg::ST_DONE:
                r_hit <= (r_deb_left == '0) && (range_w > {1'b0, r_threshold});
            default: ;
        endcase
    end

    `TRGD_ASSERT(a_ready_idle, i_clk, i_rst_n,
        s_axis_tready |-> !m_axis_tvalid, "input and output busy together")
    `TRGD_ASSERT(a_hit_taken, i_clk, i_rst_n,
        (m_axis_tvalid && m_axis_tdata[0]) |-> m_axis_tdata[1], "hit without sample")
    `TRGD_ASSERT(a_untaken_zero, i_clk, i_rst_n,
        (m_axis_tvalid && !m_axis_tdata[1]) |-> (m_axis_tdata[17:2] == 16'd0),
        "pitch nonzero on dropped sample")
    `TRGD_ASSERT(a_one_result, i_clk, i_rst_n,
        out_acc |=> s_axis_tready, "result not retired")
endmodule

// File: dv/tilt_range_gesture_detector_tb.sv
// Self-checking bench for the tilt range gesture detector: drives samples over the
// input stream, predicts pitch, window range and debounce, checks every result.
// Depends on trgd_pkg and the detector RTL.
module tilt_range_gesture_detector_tb;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [31:0] now_ms;
        logic [15:0] z;
        logic [15:0] y;
        logic [15:0] x;
    } t_sample;

    typedef struct packed {
        logic [15:0] pitch;
        logic        taken;
        logic        detected;
    } t_verdict;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [79:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_index = trgd_pkg::CfgEnable;
    logic [15:0] i_cfg_data = '0;

    tilt_range_gesture_detector i_dut (.*);

    // predictor state
    logic        cfg_en;
    logic [15:0] cfg_thr;
    logic [15:0] cfg_gap;
    logic [5:0]  cfg_deb;
    logic signed [15:0] win [trgd_pkg::WindowDepth];
    int unsigned slot;
    logic [31:0] last_ms;
    logic [5:0]  deb_left;

    t_sample  pending_q[$];
    t_verdict expected_q[$];
    int       errors = 0;
    int       cycles = 0;
    int       burst_left = 0;
    int       gap_left = 0;
    bit       hold_send = 1'b0;

    localparam longint AtanTab[trgd_pkg::CordicSteps] = '{
        2949120, 1740967, 919879, 466945, 234379, 117305, 58666, 29335,
        14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7};

    function automatic longint floor_shr(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint int_sqrt(longint unsigned n);
        longint unsigned res = 0, bitv = 64'd1 << 62;
        while (bitv > n) bitv >>= 2;
        while (bitv != 0) begin
            if (n >= res + bitv) begin
                n -= res + bitv;
                res = (res >> 1) + bitv;
            end else begin
                res >>= 1;
            end
            bitv >>= 2;
        end
        return longint'(res);
    endfunction

    function automatic logic signed [15:0] pitch_of(logic signed [15:0] ax,
            logic signed [15:0] ay, logic signed [15:0] az);
        longint sum, cx, cy, ang, dx, dy, q;
        sum = longint'(ay) * ay + longint'(az) * az;
        cx = int_sqrt(longint'(sum) << 16);
        cy = -longint'(ax) * 256;
        ang = 0;
        if (cy == 0) return 16'sd0;
        if (cx == 0) return cy > 0 ? 16'sd23040 : -16'sd23040;
        for (int i = 0; i < trgd_pkg::CordicSteps; i++) begin
            dx = floor_shr(cy, i);
            dy = floor_shr(cx, i);
            if (cy > 0) begin
                cx += dx; cy -= dy; ang += AtanTab[i];
            end else begin
                cx -= dx; cy += dy; ang -= AtanTab[i];
            end
        end
        q = floor_shr(ang + 128, 8);
        if (q > trgd_pkg::PitchLimit) q = trgd_pkg::PitchLimit;
        if (q < -trgd_pkg::PitchLimit) q = -trgd_pkg::PitchLimit;
        return 16'(q);
    endfunction

    function automatic t_verdict predict_sample(t_sample s);
        t_verdict v;
        logic signed [15:0] p, mn, mx;
        v = '0;
        if (!cfg_en || (s.now_ms - last_ms) < {16'd0, cfg_gap}) return v;
        last_ms = s.now_ms;
        p = pitch_of(s.x, s.y, s.z);
        win[slot] = p;
        slot = (slot + 1) % trgd_pkg::WindowDepth;
        mn = win[0];
        mx = win[0];
        for (int i = 1; i < trgd_pkg::WindowDepth; i++) begin
            if (win[i] < mn) mn = win[i];
            if (win[i] > mx) mx = win[i];
        end
        if (deb_left == 0 && (int'(mx) - int'(mn)) > int'(cfg_thr)) begin
            deb_left = cfg_deb;
            v.detected = 1'b1;
        end else if (deb_left > 0) begin
            deb_left--;
        end
        v.taken = 1'b1;
        v.pitch = p;
        return v;
    endfunction

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // driver: bursts with random gaps, optional hold until drained
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) begin
                expected_q.push_back(predict_sample(t_sample'(s_axis_tdata)));
                void'(pending_q.pop_front());
            end
            if (s_axis_tvalid && !(s_axis_tready)) begin
                // hold current transaction
            end else if (pending_q.size() > (s_axis_tvalid && s_axis_tready ? 0 : 0)
                    && !(hold_send && expected_q.size() > 0) && gap_left == 0
                    && pending_q.size() > 0) begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata <= pending_q[0];
                if (burst_left == 0) begin
                    burst_left <= $urandom_range(1, 12);
                end else if (burst_left == 1) begin
                    burst_left <= 0;
                    gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 90);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                s_axis_tvalid <= 1'b0;
                if (gap_left > 0) gap_left <= gap_left - 1;
            end
        end
    end

    // monitor and result sink with its own stall pattern
    always @(posedge i_clk) begin
        t_verdict got, want;
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                got = m_axis_tdata[17:0];
                if (m_axis_tdata[23:18] != 0 || expected_q.size() == 0) begin
                    errors <= errors + 1;
                    if (errors < 10)
                        $display("unexpected result or nonzero pad: %h", m_axis_tdata);
                end else begin
                    want = expected_q.pop_front();
                    if (got !== want) begin
                        errors <= errors + 1;
                        if (errors < 10)
                            $display({"mismatch: exp det=%0b taken=%0b pitch=%0d,",
                                      " got det=%0b taken=%0b pitch=%0d"},
                                want.detected, want.taken, $signed(want.pitch),
                                got.detected, got.taken, $signed(got.pitch));
                    end
                end
            end
            m_axis_tready <= (cycles % 512 < 128) ? 1'b1 : ($urandom_range(0, 3) != 0);
        end
    end

    task automatic write_cfg(logic [1:0] idx, logic [15:0] val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        case (idx)
            trgd_pkg::CfgEnable:    cfg_en = val[0];
            trgd_pkg::CfgThreshold: cfg_thr = val;
            trgd_pkg::CfgInterval:  cfg_gap = val;
            default:                cfg_deb = val[5:0];
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic drain();
        while (pending_q.size() > 0 || s_axis_tvalid || expected_q.size() > 0)
            @(posedge i_clk);
        repeat (80) @(posedge i_clk);
    endtask

    task automatic add_sample(logic [15:0] x, logic [15:0] y, logic [15:0] z, logic [31:0] t);
        t_sample s;
        s.x = x; s.y = y; s.z = z; s.now_ms = t;
        pending_q.push_back(s);
    endtask

    logic [31:0] clock_ms;

    task automatic random_phase(int n, int step_max);
        for (int i = 0; i < n; i++) begin
            clock_ms += $urandom_range(0, step_max);
            case ($urandom_range(0, 3))
                0: add_sample(16'($urandom), 16'($urandom), 16'($urandom), clock_ms);
                1: add_sample(16'($urandom_range(0, 8191) - 4096),
                              16'($urandom_range(0, 8191) - 4096),
                              16'($urandom_range(0, 8191) - 4096), clock_ms);
                2: add_sample(16'($urandom), 16'd0, 16'd0, clock_ms);
                default: add_sample(16'd0, 16'($urandom), 16'($urandom), $urandom);
            endcase
        end
    endtask

    initial begin
        cfg_en = 1'b1; cfg_thr = 16'd5120; cfg_gap = 16'd20; cfg_deb = 6'd40;
        foreach (win[i]) win[i] = '0;
        slot = 0; last_ms = '0; deb_left = '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        // directed: extremes, zero vectors, wrap of time, too-early samples
        clock_ms = 32'd0;
        add_sample(16'h8000, 16'h8000, 16'h8000, 32'd19);
        add_sample(16'h8000, 16'h0, 16'h0, 32'd20);
        add_sample(16'h7FFF, 16'h0, 16'h0, 32'd40);
        add_sample(16'h0, 16'h0, 16'h0, 32'd60);
        add_sample(16'h7FFF, 16'h7FFF, 16'h7FFF, 32'd80);
        add_sample(16'hFFFF, 16'h8000, 16'h7FFF, 32'hFFFF_FFFF);
        add_sample(16'h0001, 16'h0001, 16'h0, 32'h0000_0010);
        add_sample(16'h0800, 16'h0, 16'h0800, 32'h0000_0040);
        drain();
        write_cfg(trgd_pkg::CfgDebounce, 16'd0);
        write_cfg(trgd_pkg::CfgInterval, 16'd0);
        write_cfg(trgd_pkg::CfgThreshold, 16'd0);
        add_sample(16'h8000, 16'h0, 16'h0, 32'd0);
        add_sample(16'h7FFF, 16'h0, 16'h0, 32'd0);
        add_sample(16'h8000, 16'h0, 16'h0, 32'd0);
        add_sample(16'h7FFF, 16'h0, 16'h0, 32'd0);
        drain();
        write_cfg(trgd_pkg::CfgEnable, 16'd0);
        hold_send = 1'b0;
        add_sample(16'h8000, 16'h1, 16'h1, 32'd500);
        drain();
        write_cfg(trgd_pkg::CfgEnable, 16'hFFFF);
        write_cfg(trgd_pkg::CfgThreshold, 16'd46080);
        clock_ms = 32'd1000;
        random_phase(150, 3);
        drain();
        write_cfg(trgd_pkg::CfgThreshold, 16'd2000);
        write_cfg(trgd_pkg::CfgDebounce, 16'd63);
        write_cfg(trgd_pkg::CfgInterval, 16'd5);
        // hold each new sample until every expected result has come back
        hold_send = 1'b1;
        random_phase(200, 8);
        drain();
        hold_send = 1'b0;
        write_cfg(trgd_pkg::CfgInterval, 16'hFFFF);
        write_cfg(trgd_pkg::CfgThreshold, 16'd9000);
        write_cfg(trgd_pkg::CfgDebounce, 16'd3);
        random_phase(60, 40000);
        drain();
        write_cfg(trgd_pkg::CfgInterval, 16'd0);
        write_cfg(trgd_pkg::CfgThreshold, 16'd300);
        random_phase(280, 2);
        drain();
        if (errors == 0) begin
            $display("tilt_range_gesture_detector test passed");
        end else begin
            $display("tilt_range_gesture_detector test failed");
        end
        $finish;
    end

    // cycle limit
    initial begin
        wait (cycles >= 400000);
        $display("tilt_range_gesture_detector test failed");
        $finish;
    end
endmodule
